>>> hw/rtl/dsps_pkg.sv
// Shared types, codes and phase tables for the dual stepper phase sequencer.
// No dependencies; used by dsps_seq and dual_stepper_phase_sequencer_unit.
package dsps_pkg;

	localparam int STEP_W   = 10;
	localparam int WORD_W   = 16;
	localparam int PERIOD_W = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_AB_RST = 16'd1000;
	localparam logic [PERIOD_W-1:0] PERIOD_CD_RST = 16'd1800;

	localparam logic [WORD_W-1:0] OFF_WORD_AB = 16'h0000;
	localparam logic [WORD_W-1:0] OFF_WORD_CD = 16'h0008;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_MOVE = 2'd1,
		FUNC_OFF  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_STEP    = 2'd0,
		KIND_OFF     = 2'd1,
		KIND_REFUSED = 2'd2
	} kind_t;

	typedef enum logic {
		REG_PERIOD_AB = 1'b0,
		REG_PERIOD_CD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        func;
		logic              motor;
		logic              direction;
		logic [STEP_W-1:0] step_count;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] spi_word;
		logic [1:0]        kind;
	} out_t;

	// result of one item as it leaves the sequencer core
	typedef struct packed {
		logic valid;
		out_t data;
	} res_t;

	// A/B half-step table, eight phases
	function automatic logic [WORD_W-1:0] ab_word(input logic [2:0] ph);
		logic [WORD_W-1:0] w;
		case (ph)
			3'd0:    w = 16'hF3C0;
			3'd1:    w = 16'hF800;
			3'd2:    w = 16'hF2C0;
			3'd3:    w = 16'h32E0;
			3'd4:    w = 16'hB2C0;
			3'd5:    w = 16'hB8C0;
			3'd6:    w = 16'hB3C0;
			default: w = 16'h03E0;
		endcase
		return w;
	endfunction

	// C/D full-step table, four phases
	function automatic logic [WORD_W-1:0] cd_word(input logic [1:0] ph);
		logic [WORD_W-1:0] w;
		case (ph)
			2'd0:    w = 16'hF808;
			2'd1:    w = 16'h02E8;
			2'd2:    w = 16'hB808;
			default: w = 16'h03E8;
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/dsps_seq.sv
// Sequencer core: phase, move and tick-timer state plus the per-beat decode.
// Depends on dsps_pkg. Result is combinational; the top level registers it.
module dsps_seq #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  dsps_pkg::in_t                  item,
	input  logic [dsps_pkg::PERIOD_W-1:0]  period_ab,
	input  logic [dsps_pkg::PERIOD_W-1:0]  period_cd,
	output dsps_pkg::res_t                 res
);

	logic [2:0]                    phase_ab_q, phase_ab_d;
	logic [1:0]                    phase_cd_q, phase_cd_d;
	logic                          busy_q, busy_d;
	logic                          motor_q, motor_d;
	logic                          dir_q, dir_d;
	logic [COUNT_WIDTH-1:0]        steps_q, steps_d;
	logic [dsps_pkg::PERIOD_W-1:0] timer_q, timer_d;

	logic [COUNT_WIDTH+dsps_pkg::STEP_W-1:0] count_wide;
	logic [COUNT_WIDTH-1:0]        count;
	logic [COUNT_WIDTH-1:0]        steps_dec;
	logic [COUNT_WIDTH-1:0]        count_dec;
	logic                          adv_motor, adv_dir;
	logic [2:0]                    ab_next;
	logic [1:0]                    cd_next;
	logic [dsps_pkg::WORD_W-1:0]   adv_word;
	logic [dsps_pkg::PERIOD_W-1:0] period_raw, period_sel;

	// step_count is ten bits; the move counter may be narrower or wider
	assign count_wide = {{COUNT_WIDTH{1'b0}}, item.step_count};
	assign count      = count_wide[COUNT_WIDTH-1:0];
	assign steps_dec  = COUNT_WIDTH'(steps_q - 1'b1);
	assign count_dec  = COUNT_WIDTH'(count - 1'b1);

	// ticks advance the running move, a command advances its own motor
	assign adv_motor = busy_q ? motor_q : item.motor;
	assign adv_dir   = busy_q ? dir_q   : item.direction;
	assign ab_next   = adv_dir ? 3'(phase_ab_q + 3'd1) : 3'(phase_ab_q + 3'd7);
	assign cd_next   = adv_dir ? 2'(phase_cd_q + 2'd1) : 2'(phase_cd_q + 2'd3);
	assign adv_word  = adv_motor ? dsps_pkg::cd_word(cd_next) : dsps_pkg::ab_word(ab_next);

	assign period_raw = adv_motor ? period_cd : period_ab;
	assign period_sel = (period_raw == '0) ? dsps_pkg::PERIOD_W'(1) : period_raw;

	always_comb begin
		phase_ab_d = phase_ab_q;
		phase_cd_d = phase_cd_q;
		busy_d     = busy_q;
		motor_d    = motor_q;
		dir_d      = dir_q;
		steps_d    = steps_q;
		timer_d    = timer_q;
		res        = '0;
		if (item_valid) begin
			unique case (dsps_pkg::func_t'(item.func))
				dsps_pkg::FUNC_TICK: begin
					if (busy_q) begin
						if (timer_q > dsps_pkg::PERIOD_W'(1)) begin
							timer_d = timer_q - 1'b1;
						end else begin
							res.valid         = 1'b1;
							res.data.spi_word = adv_word;
							res.data.kind     = dsps_pkg::KIND_STEP;
							if (motor_q) phase_cd_d = cd_next;
							else         phase_ab_d = ab_next;
							steps_d = steps_dec;
							if (steps_dec == '0) begin
								busy_d  = 1'b0;
								timer_d = '0;
							end else begin
								timer_d = period_sel;
							end
						end
					end
				end
				dsps_pkg::FUNC_MOVE, dsps_pkg::FUNC_OFF: begin
					if (busy_q) begin
						res.valid = 1'b1;
						res.data.kind = dsps_pkg::KIND_REFUSED;
					end else if (item.func == dsps_pkg::FUNC_OFF) begin
						res.valid = 1'b1;
						res.data.spi_word = item.motor ? dsps_pkg::OFF_WORD_CD
						                               : dsps_pkg::OFF_WORD_AB;
						res.data.kind = dsps_pkg::KIND_OFF;
					end else if (count != '0) begin
						res.valid         = 1'b1;
						res.data.spi_word = adv_word;
						res.data.kind     = dsps_pkg::KIND_STEP;
						if (item.motor) phase_cd_d = cd_next;
						else            phase_ab_d = ab_next;
						steps_d = count_dec;
						if (count_dec != '0) begin
							busy_d  = 1'b1;
							motor_d = item.motor;
							dir_d   = item.direction;
							timer_d = period_sel;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ab_q <= '0;
			phase_cd_q <= '0;
			busy_q     <= 1'b0;
			motor_q    <= 1'b0;
			dir_q      <= 1'b0;
			steps_q    <= '0;
			timer_q    <= '0;
		end else begin
			phase_ab_q <= phase_ab_d;
			phase_cd_q <= phase_cd_d;
			busy_q     <= busy_d;
			motor_q    <= motor_d;
			dir_q      <= dir_d;
			steps_q    <= steps_d;
			timer_q    <= timer_d;
		end
	end

	a_busy_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> steps_q != '0)
		else $error("busy with no steps left");

	a_busy_timer: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> timer_q != '0)
		else $error("busy with timer at zero");

	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> timer_q == '0)
		else $error("timer running while idle");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.kind == dsps_pkg::KIND_REFUSED |->
			res.data.spi_word == '0 && busy_q)
		else $error("refused beat with nonzero word or while idle");

endmodule

>>> hw/rtl/dual_stepper_phase_sequencer_unit.sv
// Top level: input register, period registers, sequencer core, output register.
// Depends on dsps_pkg and dsps_seq.
//
//  port group    dir   payload  moves
//  in_*          in    in_t     func, motor, direction, step_count
//  out_*         out   out_t    spi_word, kind
//  cfg_*         in    16 bit   period_ab (idx 0), period_cd (idx 1)
//
// One beat per cycle sustained while out_stall is low; a beat accepted on in passes through
// the input register, then the result register, before its result is on out.
// The sequencer state is updated as the beat leaves the input register.
// While the result register is full, out_stall holds it and a full input register.
// Reset clears all control state; periods reset to 1000 and 1800.
module dual_stepper_phase_sequencer_unit #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dsps_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dsps_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [dsps_pkg::PERIOD_W-1:0] cfg_data
);

	logic                          valid_s1;
	dsps_pkg::in_t                 item_s1;
	logic                          go;
	logic [dsps_pkg::PERIOD_W-1:0] period_ab_q, period_cd_q;
	dsps_pkg::res_t                res;
	logic                          out_valid_q;
	dsps_pkg::out_t                out_data_q;

	// core advances whenever the result register can take a new beat
	assign go       = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ab_q <= dsps_pkg::PERIOD_AB_RST;
			period_cd_q <= dsps_pkg::PERIOD_CD_RST;
		end else if (cfg_we) begin
			unique case (dsps_pkg::reg_idx_t'(cfg_idx))
				dsps_pkg::REG_PERIOD_AB: period_ab_q <= cfg_data;
				dsps_pkg::REG_PERIOD_CD: period_cd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dsps_seq #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1 && go),
		.item      (item_s1),
		.period_ab (period_ab_q),
		.period_cd (period_cd_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go && valid_s1 && res.valid) begin
			out_data_q <= res.data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled beat");

	a_off_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == dsps_pkg::KIND_OFF |->
			out_data.spi_word == dsps_pkg::OFF_WORD_AB ||
			out_data.spi_word == dsps_pkg::OFF_WORD_CD)
		else $error("off beat carries a step word");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind != 2'd3)
		else $error("result kind out of range");

endmodule
